// ===== rtl/mssm_pkg.sv =====
// Shared types and constants for the multi-stack shared memory core.
// Used by the controller, the datapath, the top level and the port checker.
`timescale 1ns / 1ps
package mssm_pkg;

	localparam int unsigned IdWidth     = 4;
	localparam int unsigned ValueWidth  = 32;
	localparam int unsigned StatusWidth = 2;
	localparam int unsigned NumWidth    = 5;
	localparam int unsigned SizeWidth   = 8;
	localparam int unsigned FillWidth   = 8;
	localparam int unsigned CfgWidth    = 8;
	// Widest address the layout can form: 15 * 255 + 255 = 4080 fits in 12 bits.
	localparam int unsigned LayoutAddrWidth = 13;

	typedef enum logic [StatusWidth-1:0] {
		STATUS_OK      = 2'd0,
		STATUS_FULL    = 2'd1,
		STATUS_EMPTY   = 2'd2,
		STATUS_INVALID = 2'd3
	} status_t;

	typedef enum logic {
		REQ_PUSH = 1'b0,
		REQ_POP  = 1'b1
	} req_t;

	typedef enum logic {
		CFG_NUM_STACKS = 1'b0,
		CFG_STACK_SIZE = 1'b1
	} cfg_index_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_READ
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;    // register the incoming request word
		logic rd;         // pop hit: read memory, drop the fill count
		logic fin_direct; // finish a push or a refused request into the output slot
		logic fin_pop;    // finish a pop with the memory read data
	} ctrl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic pop_ok;   // held request is a pop on a valid, non-empty stack
		logic out_free; // output slot is empty or being drained this cycle
	} dp_status_t;

endpackage

// ===== rtl/mssm_ctrl.sv =====
// Controller state machine of the multi-stack shared memory core.
// Depends on mssm_pkg for the state, command and status types.
`timescale 1ns / 1ps
module mssm_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  mssm_pkg::dp_status_t  status,
	output mssm_pkg::ctrl_cmd_t   cmd
);

	mssm_pkg::state_t state_q, state_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mssm_pkg::ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		unique case (state_q)
			mssm_pkg::ST_IDLE: begin
				if (in_valid) state_next = mssm_pkg::ST_EXEC;
			end
			mssm_pkg::ST_EXEC: begin
				if (status.pop_ok) begin
					state_next = mssm_pkg::ST_READ;
				end else if (status.out_free) begin
					state_next = mssm_pkg::ST_IDLE;
				end
			end
			mssm_pkg::ST_READ: begin
				if (status.out_free) state_next = mssm_pkg::ST_IDLE;
			end
			default: state_next = mssm_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready       = 1'b0;
		cmd            = '0;
		unique case (state_q)
			mssm_pkg::ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid;
			end
			mssm_pkg::ST_EXEC: begin
				cmd.rd         = status.pop_ok;
				cmd.fin_direct = !status.pop_ok && status.out_free;
			end
			mssm_pkg::ST_READ: begin
				cmd.fin_pop = status.out_free;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

endmodule

// ===== rtl/mssm_datapath.sv =====
// Datapath of the multi-stack shared memory core: layout registers, fill
// counters, the shared word memory and the output register. Uses mssm_pkg.
`timescale 1ns / 1ps
module mssm_datapath #(
	parameter int unsigned DEPTH      = 128,
	parameter int unsigned MAX_STACKS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wr_en,
	input  logic                                cfg_index,
	input  logic [mssm_pkg::CfgWidth-1:0]       cfg_data,
	input  logic                                in_req_type,
	input  logic [mssm_pkg::IdWidth-1:0]        in_stack_id,
	input  logic [mssm_pkg::ValueWidth-1:0]     in_value,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [mssm_pkg::StatusWidth-1:0]    out_status,
	output logic [mssm_pkg::ValueWidth-1:0]     out_data,
	input  mssm_pkg::ctrl_cmd_t                 cmd,
	output mssm_pkg::dp_status_t                status
);

	localparam int unsigned NumFill = (MAX_STACKS < (1 << mssm_pkg::IdWidth)) ?
		MAX_STACKS : (1 << mssm_pkg::IdWidth);
	localparam int unsigned FW  = (NumFill > 1) ? $clog2(NumFill) : 1;
	localparam int unsigned AW  = $clog2(DEPTH);
	localparam int unsigned AXW = (AW > mssm_pkg::LayoutAddrWidth) ?
		AW : mssm_pkg::LayoutAddrWidth;

	logic [mssm_pkg::NumWidth-1:0]   num_stacks_q;
	logic [mssm_pkg::SizeWidth-1:0]  stack_size_q;
	logic [mssm_pkg::FillWidth-1:0]  fill_q [NumFill];
	logic [mssm_pkg::ValueWidth-1:0] mem [DEPTH];

	logic                            req_pop_q;
	logic [mssm_pkg::IdWidth-1:0]    req_id_q;
	logic [mssm_pkg::ValueWidth-1:0] req_value_q;

	logic                            pop_in_mem_q;
	logic [mssm_pkg::ValueWidth-1:0] rd_data_q;
	logic                            out_valid_q;
	logic [mssm_pkg::StatusWidth-1:0] out_status_q;
	logic [mssm_pkg::ValueWidth-1:0] out_data_q;

	logic                            id_valid;
	logic [FW-1:0]                   fill_idx;
	logic [mssm_pkg::FillWidth-1:0]  fill;
	logic [AXW-1:0]                  base_addr;
	logic [AXW-1:0]                  push_addr;
	logic [AXW-1:0]                  pop_addr;
	logic                            push_in_mem;
	logic                            pop_in_mem;
	logic                            full;
	logic                            push_ok;
	logic [mssm_pkg::StatusWidth-1:0] direct_status;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_stacks_q <= mssm_pkg::NumWidth'(1);
			stack_size_q <= mssm_pkg::SizeWidth'(128);
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				mssm_pkg::CFG_NUM_STACKS:
					num_stacks_q <= cfg_data[mssm_pkg::NumWidth-1:0];
				mssm_pkg::CFG_STACK_SIZE:
					stack_size_q <= cfg_data[mssm_pkg::SizeWidth-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_pop_q   <= in_req_type;
			req_id_q    <= in_stack_id;
			req_value_q <= in_value;
		end
	end

	// Request decode and region address arithmetic.
	always_comb begin
		id_valid = ({1'b0, req_id_q} < num_stacks_q) && (32'(req_id_q) < NumFill);
		fill_idx = FW'(req_id_q);
		fill     = id_valid ? fill_q[fill_idx] : '0;
		base_addr = AXW'(req_id_q) * AXW'(stack_size_q);
		push_addr = base_addr + AXW'(fill);
		pop_addr  = push_addr - AXW'(1);
		push_in_mem = ({1'b0, push_addr} < (AXW+1)'(DEPTH));
		pop_in_mem  = ({1'b0, pop_addr} < (AXW+1)'(DEPTH));
		full      = (fill >= stack_size_q) || !push_in_mem;
		push_ok   = id_valid && !req_pop_q && !full;
		priority if (!id_valid) begin
			direct_status = mssm_pkg::STATUS_INVALID;
		end else if (req_pop_q) begin
			direct_status = mssm_pkg::STATUS_EMPTY;
		end else if (full) begin
			direct_status = mssm_pkg::STATUS_FULL;
		end else begin
			direct_status = mssm_pkg::STATUS_OK;
		end
	end

	assign status.pop_ok   = id_valid && req_pop_q && (fill != '0);
	assign status.out_free = !out_valid_q || out_ready;

	// A register write sets up the layout anew and empties every stack.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NumFill; i++) fill_q[i] <= '0;
		end else if (cfg_wr_en) begin
			for (int i = 0; i < NumFill; i++) fill_q[i] <= '0;
		end else if (cmd.rd) begin
			fill_q[fill_idx] <= fill - mssm_pkg::FillWidth'(1);
		end else if (cmd.fin_direct && push_ok) begin
			fill_q[fill_idx] <= fill + mssm_pkg::FillWidth'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.fin_direct && push_ok) begin
			mem[push_addr[AW-1:0]] <= req_value_q;
		end
		if (cmd.rd) begin
			rd_data_q    <= mem[pop_addr[AW-1:0]];
			pop_in_mem_q <= pop_in_mem;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.fin_direct || cmd.fin_pop) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.fin_direct) begin
			out_status_q <= direct_status;
			out_data_q   <= '0;
		end else if (cmd.fin_pop) begin
			out_status_q <= mssm_pkg::STATUS_OK;
			out_data_q   <= pop_in_mem_q ? rd_data_q : '0;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_status = out_status_q;
	assign out_data   = out_data_q;

endmodule

// ===== rtl/multi_stack_shared_memory_core.sv =====
// Top level of the multi-stack shared memory core.
// Instantiates mssm_ctrl and mssm_datapath; uses mssm_pkg.
`timescale 1ns / 1ps
// Several LIFO stacks share one word memory of DEPTH entries. Stack i owns
// the words from i * stack_size up to (i + 1) * stack_size - 1.
// The request channel (s_*) carries one word per request: s_tuser holds the
// operation (bit 0: 0 push, 1 pop) and the stack number (bits 4:1), s_tdata
// holds the value to push. The result channel (m_*) answers every request
// with exactly one word: m_tuser is the status (ok, full, empty, invalid
// stack) and m_tdata the popped value, zero unless a pop succeeds.
// The block handles one request at a time. A push or a refused request
// is finished straight into the output register; a successful pop first
// passes through the registered memory read stage. The next request is
// accepted once the previous one has been placed in the output register.
// The output register separates the two sides: a stalled receiver holds the
// result stable, and a new request is still taken; it waits to finish until
// the output register is drained.
// Writing either layout register (cfg_index 0: number of stacks, 1: words per
// stack) empties every stack. Reset clears the layout to one stack of 128
// words, empties all stacks and needs no clearing pass; memory contents are
// undefined until pushed.
module multi_stack_shared_memory_core #(
	parameter int unsigned DEPTH      = 128,
	parameter int unsigned MAX_STACKS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wr_en,
	input  logic                                cfg_index,
	input  logic [mssm_pkg::CfgWidth-1:0]       cfg_data,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [31:0]                         s_tdata,  // value[31:0]
	input  logic [4:0]                          s_tuser,  // req_type[0], stack_id[4:1]
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [31:0]                         m_tdata,  // data[31:0]
	output logic [1:0]                          m_tuser   // status[1:0]
);

	mssm_pkg::ctrl_cmd_t  cmd;
	mssm_pkg::dp_status_t dp_status;

	mssm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.status   (dp_status),
		.cmd      (cmd)
	);

	mssm_datapath #(
		.DEPTH      (DEPTH),
		.MAX_STACKS (MAX_STACKS)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_req_type (s_tuser[0]),
		.in_stack_id (s_tuser[4:1]),
		.in_value    (s_tdata),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.out_status  (m_tuser),
		.out_data    (m_tdata),
		.cmd         (cmd),
		.status      (dp_status)
	);

endmodule

// ===== rtl/mssm_checker.sv =====
// Port-level checker for multi_stack_shared_memory_core, bound to the top.
// Uses mssm_pkg for the status codes.
`timescale 1ns / 1ps
module mssm_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata,
	input logic [1:0]  m_tuser
);

	logic in_acc;
	assign in_acc = s_tvalid && s_tready;

	// A stalled result word holds its contents.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled result word changed");

	// Requests are handled one at a time.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> !s_tready)
		else $error("request accepted while another is in flight");

	// Only a successful pop carries data.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser != mssm_pkg::STATUS_OK) |-> (m_tdata == '0))
		else $error("refused request carries nonzero data");

	// A new result word follows an accepted request.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(in_acc, 2) || $past(in_acc, 3))
		else $error("result without a matching request");

endmodule

bind multi_stack_shared_memory_core mssm_checker u_mssm_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

// ===== sim/multi_stack_shared_memory_core_tb.sv =====
// Self-checking testbench for multi_stack_shared_memory_core.
// A directed stimulus table is followed by random phases under different stack layouts.
// Depends on mssm_pkg and the core RTL only.
`timescale 1ns / 1ps
module multi_stack_shared_memory_core_tb;

	localparam int unsigned MEM_WORDS  = 128;
	localparam int unsigned SLOT_COUNT = 16;
	localparam int unsigned CLK_HALF   = 6;
	// Watchdog limit for the whole run, well above what the longest correct run needs.
	localparam longint unsigned RUN_LIMIT_NS = 64'd4800000;

	typedef struct packed {
		mssm_pkg::status_t status;
		logic [31:0]       data;
	} result_t;

	// One line of the directed table: a layout register write, a request whose
	// result comes from the predictor, or a request with its result typed in.
	typedef enum logic [1:0] {
		ROW_REQ,
		ROW_CHECKED,
		ROW_CFG
	} row_kind_t;

	typedef struct packed {
		row_kind_t            kind;
		mssm_pkg::cfg_index_t reg_sel;
		logic [7:0]           reg_val;
		mssm_pkg::req_t       op;
		logic [3:0]           id;
		logic [31:0]          value;
		mssm_pkg::status_t    st;
		logic [31:0]          dat;
	} row_t;

	logic        clk;
	logic        arst_n    = 1'b0;
	logic        cfg_wr_en = 1'b0;
	logic        cfg_index = mssm_pkg::CFG_NUM_STACKS;
	logic [7:0]  cfg_data  = '0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata   = '0; // value[31:0]
	logic [4:0]  s_tuser   = '0; // req_type[0], stack_id[4:1]
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [31:0] m_tdata;        // data[31:0]
	logic [1:0]  m_tuser;        // status[1:0]

	// Shadow copy of the core: layout registers, per-stack fill levels and the
	// shared word memory. Only words pushed since the last emptying are read.
	logic [4:0]  num_stacks_q;
	logic [7:0]  stack_size_q;
	logic [7:0]  fill_q [SLOT_COUNT];
	logic [31:0] word_mem [MEM_WORDS];

	result_t pending_results[$];
	row_t    directed_rows[$];
	int      mismatch_count = 0;
	int      gap_pct        = 0;
	int      stall_pct      = 0;

	multi_stack_shared_memory_core #(
		.DEPTH      (MEM_WORDS),
		.MAX_STACKS (SLOT_COUNT)
	) uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #(CLK_HALF) clk = ~clk;
	end

	// Works out the result of one request and updates the shadow state the
	// same way the core does. Stacks own disjoint regions, so a push can only
	// land inside its own region and below the end of memory.
	function automatic result_t apply_request(mssm_pkg::req_t op, logic [3:0] id,
			logic [31:0] value);
		result_t     res;
		int unsigned base;
		int unsigned fill;
		int unsigned addr;
		res.status = mssm_pkg::STATUS_OK;
		res.data   = '0;
		if (id >= num_stacks_q) begin
			res.status = mssm_pkg::STATUS_INVALID;
		end else begin
			base = id * stack_size_q;
			fill = fill_q[id];
			if (op == mssm_pkg::REQ_PUSH) begin
				addr = base + fill;
				if (fill >= stack_size_q || addr >= MEM_WORDS) begin
					res.status = mssm_pkg::STATUS_FULL;
				end else begin
					word_mem[addr] = value;
					fill_q[id]     = fill_q[id] + 8'd1;
				end
			end else if (fill == 0) begin
				res.status = mssm_pkg::STATUS_EMPTY;
			end else begin
				addr       = base + fill - 1;
				res.data   = word_mem[addr];
				fill_q[id] = fill_q[id] - 8'd1;
			end
		end
		return res;
	endfunction

	// Presents one request word and holds it until the core takes it. The
	// expected result is queued at the edge of acceptance; s_tvalid is left
	// high so that a following word can go out back to back.
	task automatic send_request(mssm_pkg::req_t op, logic [3:0] id, logic [31:0] value,
			logic typed, result_t typed_result);
		result_t predicted;
		s_tvalid <= 1'b1;
		s_tuser  <= {id, op};
		s_tdata  <= value;
		do @(posedge clk); while (!s_tready);
		predicted = apply_request(op, id, value);
		pending_results.push_back(typed ? typed_result : predicted);
	endtask

	// Sender idling: now and then a burst of empty cycles of random length after an accepted word.
	task automatic sender_gap();
		if ($urandom_range(99) < gap_pct) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(9, 1)) @(posedge clk);
		end
	endtask

	// Stops sending and waits until every outstanding result has come back.
	task automatic wait_for_results();
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	// Layout writes happen only with the core idle. Every request gives a
	// result, so an empty queue means idle; the extra wait covers the
	// output register and the pop read stage.
	task automatic write_layout(mssm_pkg::cfg_index_t sel, logic [7:0] val);
		wait_for_results();
		repeat (4) @(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= sel;
		cfg_data  <= val;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		if (sel == mssm_pkg::CFG_NUM_STACKS) num_stacks_q = val[4:0];
		else stack_size_q = val;
		// Any layout write empties every stack.
		foreach (fill_q[k]) fill_q[k] = '0;
	endtask

	task automatic add_cfg(mssm_pkg::cfg_index_t sel, logic [7:0] val);
		row_t r;
		r         = '0;
		r.kind    = ROW_CFG;
		r.reg_sel = sel;
		r.reg_val = val;
		directed_rows.push_back(r);
	endtask

	task automatic add_req(mssm_pkg::req_t op, logic [3:0] id, logic [31:0] value);
		row_t r;
		r       = '0;
		r.kind  = ROW_REQ;
		r.op    = op;
		r.id    = id;
		r.value = value;
		directed_rows.push_back(r);
	endtask

	task automatic add_chk(mssm_pkg::req_t op, logic [3:0] id, logic [31:0] value,
			mssm_pkg::status_t st, logic [31:0] dat);
		row_t r;
		r       = '0;
		r.kind  = ROW_CHECKED;
		r.op    = op;
		r.id    = id;
		r.value = value;
		r.st    = st;
		r.dat   = dat;
		directed_rows.push_back(r);
	endtask

	// Receiver side: ready drops in random bursts.
	always @(posedge clk) begin
		int stall_left;
		if (!arst_n) begin
			m_tready   <= 1'b0;
			stall_left = 0;
		end else if (stall_left != 0) begin
			m_tready   <= 1'b0;
			stall_left = stall_left - 1;
		end else if ($urandom_range(99) < stall_pct) begin
			m_tready   <= 1'b0;
			stall_left = $urandom_range(8, 0);
		end else begin
			m_tready <= 1'b1;
		end
	end

	// Result checker: every accepted result word is matched against the
	// oldest expectation, field by field.
	always @(posedge clk) begin
		result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				$error("result word with nothing expected: status %0d data %h",
					m_tuser, m_tdata);
				mismatch_count++;
			end else begin
				want = pending_results.pop_front();
				if (m_tuser !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, m_tuser);
					mismatch_count++;
				end
				if (m_tdata !== want.data) begin
					$error("data: expected %h, got %h", want.data, m_tdata);
					mismatch_count++;
				end
			end
		end
	end

	initial begin
		#(RUN_LIMIT_NS);
		$display("== FAIL ==");
		$finish;
	end

	initial begin
		row_t           r;
		result_t        typed_res;
		mssm_pkg::req_t op;
		logic [3:0]     id;
		logic [31:0]    value;
		logic [7:0]     num_val;
		logic [7:0]     size_val;
		int             push_pct;
		int             items;
		int             id_hi;

		num_stacks_q = 5'd1;
		stack_size_q = 8'd128;
		foreach (fill_q[k]) fill_q[k] = '0;
		foreach (word_mem[k]) word_mem[k] = '0;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part. The layout after reset is one stack of 128 words.
		add_chk(mssm_pkg::REQ_POP,  4'd0,  32'h0,        mssm_pkg::STATUS_EMPTY,   32'h0);
		add_chk(mssm_pkg::REQ_PUSH, 4'd1,  32'h1,        mssm_pkg::STATUS_INVALID, 32'h0);
		add_chk(mssm_pkg::REQ_PUSH, 4'd15, 32'h80000000, mssm_pkg::STATUS_INVALID, 32'h0);
		add_chk(mssm_pkg::REQ_PUSH, 4'd0,  32'h7FFFFFFF, mssm_pkg::STATUS_OK,      32'h0);
		add_chk(mssm_pkg::REQ_PUSH, 4'd0,  32'h80000000, mssm_pkg::STATUS_OK,      32'h0);
		add_chk(mssm_pkg::REQ_PUSH, 4'd0,  32'hFFFFFFFF, mssm_pkg::STATUS_OK,      32'h0);
		add_chk(mssm_pkg::REQ_POP,  4'd0,  32'h0,        mssm_pkg::STATUS_OK,      32'hFFFFFFFF);
		add_chk(mssm_pkg::REQ_POP,  4'd0,  32'h0,        mssm_pkg::STATUS_OK,      32'h80000000);
		add_chk(mssm_pkg::REQ_POP,  4'd0,  32'h0,        mssm_pkg::STATUS_OK,      32'h7FFFFFFF);
		add_chk(mssm_pkg::REQ_POP,  4'd0,  32'h0,        mssm_pkg::STATUS_EMPTY,   32'h0);
		add_chk(mssm_pkg::REQ_POP,  4'd15, 32'h0,        mssm_pkg::STATUS_INVALID, 32'h0);
		// Sixteen stacks of eight words tile the whole memory.
		add_cfg(mssm_pkg::CFG_NUM_STACKS, 8'd16);
		add_cfg(mssm_pkg::CFG_STACK_SIZE, 8'd8);
		add_chk(mssm_pkg::REQ_PUSH, 4'd15, 32'hA5A5A5A5, mssm_pkg::STATUS_OK,      32'h0);
		add_req(mssm_pkg::REQ_PUSH, 4'd15, 32'h5A5A5A5A);
		add_req(mssm_pkg::REQ_POP,  4'd15, 32'h0);
		add_req(mssm_pkg::REQ_PUSH, 4'd7,  32'h00000001);
		// Zero words per stack: every push is full; the write emptied stack 15.
		add_cfg(mssm_pkg::CFG_STACK_SIZE, 8'd0);
		add_chk(mssm_pkg::REQ_PUSH, 4'd3,  32'hDEADBEEF, mssm_pkg::STATUS_FULL,    32'h0);
		add_chk(mssm_pkg::REQ_POP,  4'd15, 32'h0,        mssm_pkg::STATUS_EMPTY,   32'h0);
		// Regions of 255 words: stack 1 starts past the end of memory.
		add_cfg(mssm_pkg::CFG_STACK_SIZE, 8'd255);
		add_chk(mssm_pkg::REQ_PUSH, 4'd1,  32'h0BADF00D, mssm_pkg::STATUS_FULL,    32'h0);
		add_chk(mssm_pkg::REQ_PUSH, 4'd0,  32'h12345678, mssm_pkg::STATUS_OK,      32'h0);
		add_chk(mssm_pkg::REQ_POP,  4'd0,  32'h0,        mssm_pkg::STATUS_OK,      32'h12345678);
		// No stacks at all rejects every request.
		add_cfg(mssm_pkg::CFG_NUM_STACKS, 8'd0);
		add_chk(mssm_pkg::REQ_POP,  4'd0,  32'h0,        mssm_pkg::STATUS_INVALID, 32'h0);
		add_cfg(mssm_pkg::CFG_NUM_STACKS, 8'd31);
		add_chk(mssm_pkg::REQ_PUSH, 4'd15, 32'h00000002, mssm_pkg::STATUS_FULL,    32'h0);
		// One word per stack: the second push is full.
		add_cfg(mssm_pkg::CFG_STACK_SIZE, 8'd1);
		add_chk(mssm_pkg::REQ_PUSH, 4'd2,  32'hCAFE0001, mssm_pkg::STATUS_OK,      32'h0);
		add_chk(mssm_pkg::REQ_PUSH, 4'd2,  32'hCAFE0002, mssm_pkg::STATUS_FULL,    32'h0);
		add_req(mssm_pkg::REQ_POP,  4'd2,  32'h0);

		gap_pct   = 30;
		stall_pct = 30;
		foreach (directed_rows[n]) begin
			r = directed_rows[n];
			if (r.kind == ROW_CFG) begin
				write_layout(r.reg_sel, r.reg_val);
			end else begin
				typed_res.status = r.st;
				typed_res.data   = r.dat;
				send_request(r.op, r.id, r.value, r.kind == ROW_CHECKED, typed_res);
				sender_gap();
			end
		end

		// Random phases, each under its own layout. The phases with one big
		// stack are push-heavy and long so that the fill limit and the end of
		// memory are both reached. The last phase runs without idling.
		for (int p = 0; p < 10; p++) begin
			items    = 119;
			push_pct = $urandom_range(65, 35);
			case (p)
				0: begin
					num_val  = 8'd16;
					size_val = 8'd8;
				end
				1: begin
					num_val  = 8'd1;
					size_val = 8'd128;
					push_pct = 90;
					items    = 200;
				end
				2: begin
					num_val  = 8'd1;
					size_val = 8'd255;
					push_pct = 90;
					items    = 200;
				end
				3: begin
					num_val  = 8'd2;
					size_val = 8'd1;
				end
				4: begin
					num_val  = 8'd31;
					size_val = 8'd4;
				end
				5: begin
					num_val  = 8'd0;
					size_val = 8'd5;
				end
				default: begin
					num_val  = 8'($urandom_range(16, 1));
					size_val = 8'($urandom_range(12, 1));
				end
			endcase
			write_layout(mssm_pkg::CFG_NUM_STACKS, num_val);
			write_layout(mssm_pkg::CFG_STACK_SIZE, size_val);
			case ($urandom_range(2))
				0: gap_pct = 0;
				1: gap_pct = 20;
				default: gap_pct = 45;
			endcase
			case ($urandom_range(2))
				0: stall_pct = 0;
				1: stall_pct = 20;
				default: stall_pct = 45;
			endcase
			if (p == 9) begin
				gap_pct   = 0;
				stall_pct = 0;
			end
			id_hi = (num_stacks_q > SLOT_COUNT) ? SLOT_COUNT - 1 : num_stacks_q - 1;
			for (int i = 0; i < items; i++) begin
				op = ($urandom_range(99) < push_pct) ? mssm_pkg::REQ_PUSH : mssm_pkg::REQ_POP;
				// Mostly stacks in use, now and then any stack number.
				if (num_stacks_q == 0 || $urandom_range(9) == 0) id = 4'($urandom_range(15));
				else id = 4'($urandom_range(id_hi, 0));
				case ($urandom_range(7))
					0: value = 32'h00000000;
					1: value = 32'h7FFFFFFF;
					2: value = 32'h80000000;
					3: value = 32'hFFFFFFFF;
					default: value = $urandom;
				endcase
				typed_res = '0;
				send_request(op, id, value, 1'b0, typed_res);
				// Once, mid phase, the sender waits out every result.
				if (p == 6 && i == items / 2) wait_for_results();
				else sender_gap();
			end
		end

		wait_for_results();
		repeat (10) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
